[design/gb5_pkg.sv]
// ----------------------------------------------------------------------------
// gb5_pkg
// Shared widths, constants and types of the 5x5 Gaussian blur stream.
// ----------------------------------------------------------------------------
package gb5_pkg;

   localparam int PIXEL_W = 8;
   localparam int LW_W    = 10;
   localparam int LINES   = 4;
   localparam int WIN     = 5;
   localparam int HALO    = 4;
   localparam int ROW_W   = 12;
   localparam int SUM_W   = 16;
   localparam int WORD_W  = LINES * PIXEL_W;

   typedef logic [PIXEL_W-1:0] pixel_type;
   typedef logic [WORD_W-1:0]  word_type;
   typedef logic [2:0]         row_type;

   // one pixel leaving the line store stage for the filter
   typedef struct packed {
      pixel_type px;
      logic      last;
      logic      bypass;
      word_type  column;
   } stage_type;

endpackage

[design/gb5_line_mem.sv]
// ----------------------------------------------------------------------------
// gb5_line_mem
// Line store RAM: one word per column holds the four previous lines.
// Registered read, one write port, zero sweep after reset.
// ----------------------------------------------------------------------------
module gb5_line_mem #(
   parameter int DEPTH = 512
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             rd_en,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output gb5_pkg::word_type                rd_data,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  gb5_pkg::word_type                wr_data,
   output logic                             clearing
);

   localparam int AW = $clog2(DEPTH);

   gb5_pkg::word_type mem [DEPTH];
   gb5_pkg::word_type rd_data_ff;
   logic              clr_ff, clr_in;
   logic [AW-1:0]     clr_addr_ff, clr_addr_in;
   logic              we;
   logic [AW-1:0]     wa;
   gb5_pkg::word_type wd;

   always_comb begin
      clr_in      = clr_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_ff) begin
         clr_addr_in = clr_addr_ff + AW'(1);
         if (clr_addr_ff == AW'(DEPTH - 1)) begin
            clr_in = 1'b0;
         end
      end
      we = clr_ff | wr_en;
      wa = clr_ff ? clr_addr_ff : wr_addr;
      wd = clr_ff ? '0 : wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_ff      <= clr_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data  = rd_data_ff;
   assign clearing = clr_ff;

endmodule

[design/gb5_filter.sv]
// ----------------------------------------------------------------------------
// gb5_filter
// 5x5 window, binomial kernel sum in two add stages and result register.
// ----------------------------------------------------------------------------
module gb5_filter (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  gb5_pkg::stage_type  stage,
   output logic                free,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_pixel_out,
   output logic                rsp_last_out
);

   typedef logic [gb5_pkg::ROW_W-1:0] rsum_type;
   typedef logic [gb5_pkg::SUM_W-1:0] tsum_type;

   function automatic tsum_type weigh(input tsum_type a, input tsum_type b,
                                      input tsum_type c, input tsum_type d,
                                      input tsum_type e);
      weigh = a + (b << 2) + (c << 2) + (c << 1) + (d << 2) + e;
   endfunction

   gb5_pkg::pixel_type window_ff [gb5_pkg::WIN][gb5_pkg::WIN];
   logic               v2_ff, v2_in;
   gb5_pkg::pixel_type px2_ff;
   logic               last2_ff, byp2_ff;
   rsum_type           rsum_ff [gb5_pkg::WIN];
   logic               v3_ff, v3_in;
   gb5_pkg::pixel_type px3_ff;
   logic               last3_ff, byp3_ff;
   logic               out_v_ff, out_v_in;
   gb5_pkg::pixel_type out_px_ff;
   logic               out_last_ff;
   logic               out_free, free3, adv2, adv3;
   tsum_type           total;

   always_comb begin
      out_free = !out_v_ff || !rsp_stall;
      free3    = !v3_ff || out_free;
      free     = !v2_ff || free3;
      adv2     = v2_ff && free3;
      adv3     = v3_ff && out_free;
      v2_in    = push | (v2_ff & !adv2);
      v3_in    = adv2 | (v3_ff & !adv3);
      out_v_in = adv3 | (out_v_ff & rsp_stall);
      total    = weigh(tsum_type'(rsum_ff[0]), tsum_type'(rsum_ff[1]),
                       tsum_type'(rsum_ff[2]), tsum_type'(rsum_ff[3]),
                       tsum_type'(rsum_ff[4]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         v2_ff    <= v2_in;
         v3_ff    <= v3_in;
         out_v_ff <= out_v_in;
      end
   end

   // window slides one column per transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < gb5_pkg::WIN; r++) begin
            for (int c = 0; c < gb5_pkg::WIN; c++) begin
               window_ff[r][c] <= '0;
            end
         end
      end else if (push) begin
         for (int r = 0; r < gb5_pkg::WIN; r++) begin
            for (int c = 0; c < gb5_pkg::WIN - 1; c++) begin
               window_ff[r][c] <= window_ff[r][c+1];
            end
         end
         for (int r = 0; r < gb5_pkg::LINES; r++) begin
            window_ff[r][gb5_pkg::WIN-1] <= stage.column[r*gb5_pkg::PIXEL_W +: gb5_pkg::PIXEL_W];
         end
         window_ff[gb5_pkg::WIN-1][gb5_pkg::WIN-1] <= stage.px;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         px2_ff   <= stage.px;
         last2_ff <= stage.last;
         byp2_ff  <= stage.bypass;
      end
      if (adv2) begin
         for (int r = 0; r < gb5_pkg::WIN; r++) begin
            rsum_ff[r] <= rsum_type'(weigh(tsum_type'(window_ff[r][0]),
                                           tsum_type'(window_ff[r][1]),
                                           tsum_type'(window_ff[r][2]),
                                           tsum_type'(window_ff[r][3]),
                                           tsum_type'(window_ff[r][4])));
         end
         px3_ff   <= px2_ff;
         last3_ff <= last2_ff;
         byp3_ff  <= byp2_ff;
      end
      if (adv3) begin
         out_px_ff   <= byp3_ff ? px3_ff : total[gb5_pkg::SUM_W-1 -: gb5_pkg::PIXEL_W];
         out_last_ff <= last3_ff;
      end
   end

   assign rsp_valid     = out_v_ff;
   assign rsp_pixel_out = out_px_ff;
   assign rsp_last_out  = out_last_ff;

endmodule

[design/gaussian_blur_5x5_stream_top.sv]
// ----------------------------------------------------------------------------
// gaussian_blur_5x5_stream_top
// 5x5 Gaussian blur over a raster pixel stream, one result per pixel.
// ----------------------------------------------------------------------------
// Takes one pixel per clock and gives one pixel per clock when neither side
// stalls; a result passes the input, window, row sum and output registers
// before rsp_valid rises. The rate is set by the line store RAM, which holds
// the four previous lines as one word per column and does one read and one
// write each cycle; a write still in flight to the column being read is
// forwarded. After reset the RAM is zeroed with req_stall high (csr writes are
// taken throughout). line_width of zero or above MAX_WIDTH acts as MAX_WIDTH.
module gaussian_blur_5x5_stream_top #(
   parameter int MAX_WIDTH = 512
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [7:0]                   req_pixel_in,
   input  logic                         req_frame_end,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [7:0]                   rsp_pixel_out,
   output logic                         rsp_last_out,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [gb5_pkg::LW_W-1:0]     csr_line_width
);

   localparam int AW   = $clog2(MAX_WIDTH);
   localparam int EW   = $clog2(MAX_WIDTH + 1);
   localparam int CMPW = (EW > gb5_pkg::LW_W) ? EW : gb5_pkg::LW_W;
   localparam logic [gb5_pkg::LW_W-1:0] LW_RESET =
      (MAX_WIDTH > (2 ** gb5_pkg::LW_W) - 1) ? '0 : gb5_pkg::LW_W'(MAX_WIDTH);

   logic [gb5_pkg::LW_W-1:0] lw_ff;
   logic [AW-1:0]            col_count_ff, col_count_in;
   gb5_pkg::row_type         row_ff, row_in;
   logic [CMPW-1:0]          eff, col_x, col_p1;
   logic [AW-1:0]            col;
   logic                     accept, clearing, free2, adv1, bypass;
   logic                     v1_ff, v1_in;
   gb5_pkg::pixel_type       px1_ff;
   logic                     last1_ff, byp1_ff;
   logic [AW-1:0]            col1_ff;
   logic                     fwd_ff;
   gb5_pkg::word_type        fwd_data_ff;
   gb5_pkg::word_type        rd_data, column, wr_data;
   gb5_pkg::stage_type       stage;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lw_ff <= LW_RESET;
      end else if (csr_valid && csr_ready) begin
         lw_ff <= csr_line_width;
      end
   end

   // column and row tracking at input transfer
   always_comb begin
      if (lw_ff == '0 || CMPW'(lw_ff) > CMPW'(MAX_WIDTH)) begin
         eff = CMPW'(MAX_WIDTH);
      end else begin
         eff = CMPW'(lw_ff);
      end
      col_x  = (CMPW'(col_count_ff) >= eff) ? '0 : CMPW'(col_count_ff);
      col    = col_x[AW-1:0];
      col_p1 = col_x + CMPW'(1);
      bypass = (row_ff < 3'(gb5_pkg::HALO)) || (col_x < CMPW'(gb5_pkg::HALO));

      col_count_in = col_count_ff;
      row_in       = row_ff;
      if (accept) begin
         priority if (req_frame_end) begin
            col_count_in = '0;
            row_in       = '0;
         end else if (col_p1 >= eff) begin
            col_count_in = '0;
            if (row_ff < 3'(gb5_pkg::HALO)) begin
               row_in = row_ff + 3'd1;
            end
         end else begin
            col_count_in = col_p1[AW-1:0];
         end
      end
   end

   always_comb begin
      adv1      = v1_ff && free2;
      req_stall = clearing || (v1_ff && !free2);
      accept    = req_valid && !req_stall;
      v1_in     = accept | (v1_ff & !adv1);
      column    = fwd_ff ? fwd_data_ff : rd_data;
      wr_data   = {px1_ff, column[gb5_pkg::WORD_W-1:gb5_pkg::PIXEL_W]};
      stage.px     = px1_ff;
      stage.last   = last1_ff;
      stage.bypass = byp1_ff;
      stage.column = column;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= '0;
         row_ff       <= '0;
         v1_ff        <= 1'b0;
      end else begin
         col_count_ff <= col_count_in;
         row_ff       <= row_in;
         v1_ff        <= v1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         px1_ff      <= req_pixel_in;
         last1_ff    <= req_frame_end;
         byp1_ff     <= bypass;
         col1_ff     <= col;
         fwd_ff      <= adv1 && (col1_ff == col);
         fwd_data_ff <= wr_data;
      end
   end

   gb5_line_mem #(
      .DEPTH(MAX_WIDTH)
   ) u_line_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (col),
      .rd_data (rd_data),
      .wr_en   (adv1),
      .wr_addr (col1_ff),
      .wr_data (wr_data),
      .clearing(clearing)
   );

   gb5_filter u_filter (
      .clock        (clock),
      .reset        (reset),
      .push         (adv1),
      .stage        (stage),
      .free         (free2),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_pixel_out(rsp_pixel_out),
      .rsp_last_out (rsp_last_out)
   );

endmodule

[sim/tb_gaussian_blur_5x5_stream_top.sv]
// ----------------------------------------------------------------------------
// tb_gaussian_blur_5x5_stream_top
// Self-checking bench for the 5x5 Gaussian blur pixel stream. A directed
// table covers field extremes, line widths of zero, narrow and out of range,
// a width shrunk in mid-line and frame ends. Randomly sized frames with
// random or saturated content follow, mixed with early frame ends and cut
// lines. Every result transfer is checked against an in-bench line store and
// window model, with random gaps on the request side and random stalls on
// the result side.
// ----------------------------------------------------------------------------
module tb_gaussian_blur_5x5_stream_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          MAX_WIDTH     = 512;
   localparam int          RANDOM_PIXELS = 950;
   localparam int          DIR_ROWS      = 33;
   localparam int unsigned CYCLE_LIMIT   = 200000;
   localparam int unsigned TAPS [gb5_pkg::WIN] = '{1, 4, 6, 4, 1};

   typedef enum logic [1:0] {ROW_PIXEL, ROW_WIDTH} row_kind_type;
   typedef enum logic [1:0] {
      FILL_RANDOM, FILL_WHITE, FILL_BLACK, FILL_EXTREMES
   } fill_mode_type;

   typedef struct {
      row_kind_type        kind;
      logic [9:0]          value;
      logic                frame_end;
      logic                known;
      gb5_pkg::pixel_type  known_px;
   } dir_row_type;

   typedef struct packed {
      gb5_pkg::pixel_type pixel;
      logic               last;
   } blur_result_type;

   logic                     clock;
   logic                     reset          = 1'b1;
   logic                     req_valid      = 1'b0;
   logic                     req_stall;
   gb5_pkg::pixel_type       req_pixel_in   = '0;
   logic                     req_frame_end  = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall      = 1'b0;
   gb5_pkg::pixel_type       rsp_pixel_out;
   logic                     rsp_last_out;
   logic                     csr_valid      = 1'b0;
   logic                     csr_ready;
   logic [gb5_pkg::LW_W-1:0] csr_line_width = '0;

   // typed expectation riding along with the request
   logic                     row_known      = 1'b0;
   gb5_pkg::pixel_type       row_known_px   = '0;

   // model state
   gb5_pkg::pixel_type       line_mem [gb5_pkg::LINES][MAX_WIDTH];
   gb5_pkg::pixel_type       window_px [gb5_pkg::WIN][gb5_pkg::WIN];
   int unsigned              col_cnt        = 0;
   int unsigned              row_cnt        = 0;
   logic [gb5_pkg::LW_W-1:0] width_reg      = gb5_pkg::LW_W'(MAX_WIDTH);

   blur_result_type          pending_pixels [$];
   blur_result_type          predicted;
   blur_result_type          oldest;
   dir_row_type              dir_table [DIR_ROWS];

   int unsigned              mismatches     = 0;
   int unsigned              pixels_sent    = 0;
   int unsigned              cycle_count    = 0;
   int unsigned              req_gap_max    = 7;
   int unsigned              rsp_stall_max  = 7;

   gaussian_blur_5x5_stream_top #(
      .MAX_WIDTH(MAX_WIDTH)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pixel_in   (req_pixel_in),
      .req_frame_end  (req_frame_end),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_last_out   (rsp_last_out),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_line_width (csr_line_width)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      for (int i = 0; i < gb5_pkg::LINES; i++)
         for (int c = 0; c < MAX_WIDTH; c++)
            line_mem[i][c] = '0;
      for (int i = 0; i < gb5_pkg::WIN; i++)
         for (int j = 0; j < gb5_pkg::WIN; j++)
            window_px[i][j] = '0;
   end

   function automatic blur_result_type blur_predict(input gb5_pkg::pixel_type px,
                                                    input logic last);
      int unsigned        w;
      int unsigned        col;
      int unsigned        sum;
      gb5_pkg::pixel_type stored [gb5_pkg::LINES];
      blur_result_type    res;
      w = (width_reg == 0 || width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
      if (col_cnt >= w)
         col_cnt = 0;
      col = col_cnt;
      for (int i = 0; i < gb5_pkg::LINES; i++)
         stored[i] = line_mem[i][col];
      for (int i = 0; i < gb5_pkg::LINES - 1; i++)
         line_mem[i][col] = stored[i+1];
      line_mem[gb5_pkg::LINES-1][col] = px;
      for (int i = 0; i < gb5_pkg::WIN; i++)
         for (int j = 0; j < gb5_pkg::WIN - 1; j++)
            window_px[i][j] = window_px[i][j+1];
      for (int i = 0; i < gb5_pkg::LINES; i++)
         window_px[i][gb5_pkg::WIN-1] = stored[i];
      window_px[gb5_pkg::WIN-1][gb5_pkg::WIN-1] = px;
      if (row_cnt < gb5_pkg::HALO || col < gb5_pkg::HALO) begin
         res.pixel = px;
      end else begin
         sum = 0;
         for (int i = 0; i < gb5_pkg::WIN; i++)
            for (int j = 0; j < gb5_pkg::WIN; j++)
               sum += int'(window_px[i][j]) * TAPS[i] * TAPS[j];
         res.pixel = gb5_pkg::pixel_type'(sum >> 8);
      end
      res.last = last;
      if (last) begin
         col_cnt = 0;
         row_cnt = 0;
      end else if (col + 1 >= w) begin
         col_cnt = 0;
         if (row_cnt < gb5_pkg::HALO)
            row_cnt++;
      end else begin
         col_cnt = col + 1;
      end
      return res;
   endfunction

   function automatic gb5_pkg::pixel_type fill_pixel(input fill_mode_type mode);
      case (mode)
         FILL_WHITE:    return 8'hFF;
         FILL_BLACK:    return 8'h00;
         FILL_EXTREMES: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
         default:       return gb5_pkg::pixel_type'($urandom);
      endcase
   endfunction

   task automatic flag_error(input string msg);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch at cycle %0d: %s", cycle_count, msg);
   endtask

   // prediction on request transfers, checking on result transfers
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            width_reg = csr_line_width;
         if (req_valid && !req_stall) begin
            predicted = blur_predict(req_pixel_in, req_frame_end);
            if (row_known)
               predicted.pixel = row_known_px;
            pending_pixels.push_back(predicted);
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_pixels.size() == 0) begin
               flag_error($sformatf("unexpected result pixel_out %02h last_out %0b",
                                    rsp_pixel_out, rsp_last_out));
            end else begin
               oldest = pending_pixels.pop_front();
               if (rsp_pixel_out !== oldest.pixel)
                  flag_error($sformatf("pixel_out expected %02h got %02h",
                                       oldest.pixel, rsp_pixel_out));
               if (rsp_last_out !== oldest.last)
                  flag_error($sformatf("last_out expected %0b got %0b",
                                       oldest.last, rsp_last_out));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // result side back-pressure
   initial begin : rsp_pacing
      int unsigned hold;
      forever begin
         hold = $urandom_range(0, rsp_stall_max);
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic send_pixel(input gb5_pkg::pixel_type px, input logic last,
                             input logic known, input gb5_pkg::pixel_type known_px);
      int unsigned gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_pixel_in  <= px;
      req_frame_end <= last;
      row_known     <= known;
      row_known_px  <= known_px;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pixels_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_pixels.size() != 0);
   endtask

   task automatic change_width(input logic [gb5_pkg::LW_W-1:0] value);
      drain_results();
      csr_valid      <= 1'b1;
      csr_line_width <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase();
      int unsigned   pick;
      int unsigned   w;
      int unsigned   rows;
      int unsigned   frames;
      int unsigned   count;
      int unsigned   stop_at;
      fill_mode_type mode;
      req_gap_max   = ($urandom_range(0, 2) == 0) ? 0 : 7;
      rsp_stall_max = ($urandom_range(0, 2) == 0) ? 0 : 7;
      pick = $urandom_range(0, 15);
      if (pick == 0) begin
         // full or out of range width, pass-through only
         case ($urandom_range(0, 3))
            0:       w = 0;
            1:       w = MAX_WIDTH;
            2:       w = MAX_WIDTH + 1;
            default: w = 1023;
         endcase
         change_width(gb5_pkg::LW_W'(w));
         count = $urandom_range(20, 80);
         for (int n = 0; n < count; n++)
            send_pixel(gb5_pkg::pixel_type'($urandom), $urandom_range(0, 31) == 0,
                       1'b0, '0);
      end else if (pick == 1) begin
         // narrow lines never leave the halo
         w = $urandom_range(1, 4);
         change_width(gb5_pkg::LW_W'(w));
         count = $urandom_range(20, 40);
         for (int n = 0; n < count; n++)
            send_pixel(gb5_pkg::pixel_type'($urandom), $urandom_range(0, 7) == 0,
                       1'b0, '0);
      end else begin
         w = (pick < 12) ? $urandom_range(5, 10) : $urandom_range(11, 40);
         change_width(gb5_pkg::LW_W'(w));
         frames = $urandom_range(1, 2);
         for (int f = 0; f < frames; f++) begin
            rows = (w <= 10) ? $urandom_range(5, 7) : 5;
            mode = ($urandom_range(0, 1) != 0) ? FILL_RANDOM
                                               : fill_mode_type'($urandom_range(0, 3));
            count = rows * w;
            stop_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, count - 1) : count - 1;
            for (int n = 0; n <= stop_at; n++)
               send_pixel(fill_pixel(mode), n == stop_at, 1'b0, '0);
         end
         // cut line, next width may fall below the current column
         if ($urandom_range(0, 3) == 0) begin
            count = $urandom_range(1, w - 1);
            for (int n = 0; n < count; n++)
               send_pixel(gb5_pkg::pixel_type'($urandom), 1'b0, 1'b0, '0);
         end
      end
   endtask

   initial begin
      int unsigned random_target;
      dir_table = '{
         '{ROW_PIXEL, 10'h000, 1'b0, 1'b1, 8'h00},
         '{ROW_PIXEL, 10'h0FF, 1'b0, 1'b1, 8'hFF},
         '{ROW_PIXEL, 10'h05A, 1'b1, 1'b1, 8'h5A},
         '{ROW_WIDTH, 10'd1,   1'b0, 1'b0, 8'h00},
         '{ROW_PIXEL, 10'h0A5, 1'b0, 1'b1, 8'hA5},
         '{ROW_PIXEL, 10'h001, 1'b0, 1'b1, 8'h01},
         '{ROW_PIXEL, 10'h080, 1'b0, 1'b1, 8'h80},
         '{ROW_PIXEL, 10'h07F, 1'b0, 1'b1, 8'h7F},
         '{ROW_PIXEL, 10'h0FE, 1'b0, 1'b1, 8'hFE},
         '{ROW_PIXEL, 10'h03C, 1'b1, 1'b1, 8'h3C},
         '{ROW_WIDTH, 10'd4,   1'b0, 1'b0, 8'h00},
         '{ROW_PIXEL, 10'h011, 1'b0, 1'b1, 8'h11},
         '{ROW_PIXEL, 10'h022, 1'b0, 1'b1, 8'h22},
         '{ROW_PIXEL, 10'h033, 1'b0, 1'b1, 8'h33},
         '{ROW_PIXEL, 10'h044, 1'b1, 1'b1, 8'h44},
         '{ROW_WIDTH, 10'd0,   1'b0, 1'b0, 8'h00},
         '{ROW_PIXEL, 10'h0C3, 1'b0, 1'b1, 8'hC3},
         '{ROW_PIXEL, 10'h096, 1'b0, 1'b1, 8'h96},
         '{ROW_WIDTH, 10'd1023, 1'b0, 1'b0, 8'h00},
         '{ROW_PIXEL, 10'h069, 1'b0, 1'b1, 8'h69},
         '{ROW_WIDTH, 10'd513, 1'b0, 1'b0, 8'h00},
         '{ROW_PIXEL, 10'h00F, 1'b1, 1'b1, 8'h0F},
         '{ROW_WIDTH, 10'd8,   1'b0, 1'b0, 8'h00},
         '{ROW_PIXEL, 10'h012, 1'b0, 1'b0, 8'h00},
         '{ROW_PIXEL, 10'h09B, 1'b0, 1'b0, 8'h00},
         '{ROW_PIXEL, 10'h0E4, 1'b0, 1'b0, 8'h00},
         '{ROW_PIXEL, 10'h02D, 1'b0, 1'b0, 8'h00},
         '{ROW_PIXEL, 10'h076, 1'b0, 1'b0, 8'h00},
         '{ROW_PIXEL, 10'h0BF, 1'b0, 1'b0, 8'h00},
         '{ROW_PIXEL, 10'h008, 1'b0, 1'b0, 8'h00},
         '{ROW_WIDTH, 10'd5,   1'b0, 1'b0, 8'h00},
         '{ROW_PIXEL, 10'h0F0, 1'b0, 1'b0, 8'h00},
         '{ROW_PIXEL, 10'h00F, 1'b1, 1'b0, 8'h00}
      };
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < DIR_ROWS; r++) begin
         if (dir_table[r].kind == ROW_WIDTH)
            change_width(dir_table[r].value);
         else
            send_pixel(gb5_pkg::pixel_type'(dir_table[r].value), dir_table[r].frame_end,
                       dir_table[r].known, dir_table[r].known_px);
      end

      random_target = pixels_sent + RANDOM_PIXELS;
      while (pixels_sent < random_target)
         run_phase();

      drain_results();
      repeat (16) @(posedge clock);
      if (mismatches == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
